### design/bcts_pkg.sv
// Package for the bus controller transaction sequencer.
// Holds the item kinds, register indexes, state types and word helpers.
// No dependencies.
`default_nettype none

package bcts_pkg;

   localparam int MAX_WORDS = 32;
   localparam int ADDR_W    = $clog2(MAX_WORDS);
   localparam int COUNT_W   = 6;
   localparam int WORD_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [2:0] {
      KIND_START_SEND    = 3'd0,
      KIND_START_REQUEST = 3'd1,
      KIND_TX_EMPTY      = 3'd2,
      KIND_TX_FINISHED   = 3'd3,
      KIND_RX_WORD       = 3'd4,
      KIND_RX_SYNC       = 3'd5,
      KIND_WRITE_PAYLOAD = 3'd6,
      KIND_READ_PAYLOAD  = 3'd7
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_RT_ADDRESS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_ADDRESS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_COUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_CHANNEL_B = 2'd3;

   typedef struct packed {
      logic chan_b;
      logic sync_data;
      logic rx_on;
      logic txf_en;
      logic txe_en;
      logic tx_active;
      logic dir_req;
   } flags_type;

   typedef struct packed {
      logic              tx_valid;
      logic              tx_is_data;
      logic [WORD_W-1:0] tx_word;
      logic              tx_from_mem;
      logic              rd_from_mem;
      logic              mem_hit;
      logic              channel_select;
      logic [WORD_W-1:0] status_word;
      logic [COUNT_W-1:0] rx_count;
      logic              parity_error;
      logic              bit_fault;
      logic              receiver_on;
      logic              sync_expects_data;
      logic              transmitter_active;
   } stage_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] wc);
      logic [COUNT_W-1:0] r;
      if (wc == '0)
         r = COUNT_W'(1);
      else if (wc > COUNT_W'(MAX_WORDS))
         r = COUNT_W'(MAX_WORDS);
      else
         r = wc;
      return r;
   endfunction

   function automatic logic odd_parity(input logic [WORD_W-1:0] v);
      return ~(^v);
   endfunction

endpackage

`default_nettype wire

### design/bcts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none

module bcts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/bus_controller_transaction_sequencer.sv
// Top level of the bus controller transaction sequencer.
// Depends on bcts_pkg and bcts_ram (payload store).
//
// Usage:
//   req_ carries one event beat: tuser is the kind, tdata the slot, word and
//   receiver flags. Every beat gives exactly one rsp_ beat holding the word to
//   transmit (if any), the read-back payload word and the transaction status.
//   csr_ writes the address, subaddress, word count and channel registers;
//   write them only while no beat is in flight.
// Pipeline: an accepted request beat passes through the read stage (s1_ff, with
//   the registered payload store read) and then through the output register.
// Throughput: one beat per cycle while rsp_tready stays high; the counters and flags update in the cycle
//   a beat is taken and the store is written in that same cycle.
// Reset: counters, flags and status clear; the 32 payload valid bits clear at
//   once, so unwritten slots read as zero with no clearing pass.
// Stall: with rsp_tready low the output register and the read stage hold,
//   and req_tready drops once both are full.
`default_nettype none

module bus_controller_transaction_sequencer
   import bcts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // word_index[4:0], data_word[20:5], rx_parity[21], bit_faults[22], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tx_valid[0], tx_word_is_data[1], tx_word[17:2], channel_select[18],
   // status_word[34:19], rx_count[40:35], parity_error[41], bit_fault[42],
   // read_word[58:43], receiver_on[59], sync_expects_data[60],
   // transmitter_active[61], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [4:0]          rt_address_ff;
   logic [4:0]          sub_address_ff;
   logic [COUNT_W-1:0]  word_count_ff;
   logic                use_channel_b_ff;

   logic [COUNT_W-1:0]  words_sent_ff, words_sent_in;
   logic [COUNT_W-1:0]  words_to_send_ff, words_to_send_in;
   logic [COUNT_W-1:0]  words_received_ff, words_received_in;
   logic [COUNT_W-1:0]  words_to_receive_ff, words_to_receive_in;
   flags_type           flags_ff, flags_in;
   logic [WORD_W-1:0]   status_ff, status_in;
   logic                parity_error_ff, parity_error_in;
   logic                bit_fault_ff, bit_fault_in;
   logic [MAX_WORDS-1:0] valid_ff;

   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   kind_type            kind;
   logic [ADDR_W-1:0]   idx;
   logic [WORD_W-1:0]   data;
   logic                pbit;
   logic                bfault;
   logic                req_accept;
   logic                s1_move;
   logic [COUNT_W-1:0]  eff;
   logic [WORD_W-1:0]   cmd_word;
   logic [COUNT_W-1:0]  rx_next;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]   rd_data;
   logic [WORD_W-1:0]   tx_word_out;
   logic [WORD_W-1:0]   read_word_out;

   assign kind   = kind_type'(req_tuser[2:0]);
   assign idx    = req_tdata[ADDR_W-1:0];
   assign data   = req_tdata[20:5];
   assign pbit   = req_tdata[21];
   assign bfault = req_tdata[22];

   assign s1_move    = s1_valid_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign eff      = eff_count(word_count_ff);
   assign cmd_word = {rt_address_ff, flags_ff.dir_req, sub_address_ff, eff[4:0]};

   // event handling: counters and flags update as the beat is taken
   always_comb begin
      words_sent_in       = words_sent_ff;
      words_to_send_in    = words_to_send_ff;
      words_received_in   = words_received_ff;
      words_to_receive_in = words_to_receive_ff;
      flags_in            = flags_ff;
      status_in           = status_ff;
      parity_error_in     = parity_error_ff;
      bit_fault_in        = bit_fault_ff;
      rx_next             = words_received_ff;
      wr_en               = 1'b0;
      wr_addr             = idx;
      rd_addr             = idx;
      s1_in               = '0;
      if (req_accept) begin
         unique case (kind) inside
            KIND_START_SEND, KIND_START_REQUEST: begin
               words_sent_in     = '0;
               words_received_in = '0;
               if (kind == KIND_START_REQUEST) begin
                  words_to_send_in    = COUNT_W'(1);
                  words_to_receive_in = eff + COUNT_W'(1);
               end else begin
                  words_to_send_in    = eff + COUNT_W'(1);
                  words_to_receive_in = COUNT_W'(1);
               end
               flags_in.dir_req   = (kind == KIND_START_REQUEST);
               flags_in.txe_en    = 1'b1;
               flags_in.txf_en    = 1'b1;
               flags_in.rx_on     = 1'b1;
               flags_in.sync_data = 1'b0;
               flags_in.chan_b    = use_channel_b_ff;
            end
            KIND_TX_EMPTY: begin
               if (flags_ff.txe_en) begin
                  if (words_sent_ff == '0) begin
                     s1_in.tx_valid     = 1'b1;
                     s1_in.tx_word      = cmd_word;
                     words_sent_in      = COUNT_W'(1);
                     flags_in.tx_active = 1'b1;
                  end else if (words_sent_ff < words_to_send_ff) begin
                     s1_in.tx_valid    = 1'b1;
                     s1_in.tx_is_data  = 1'b1;
                     s1_in.tx_from_mem = 1'b1;
                     rd_addr           = ADDR_W'(words_sent_ff - COUNT_W'(1));
                     words_sent_in     = words_sent_ff + COUNT_W'(1);
                  end else begin
                     flags_in.txe_en = 1'b0;
                  end
               end
            end
            KIND_TX_FINISHED: begin
               if (flags_ff.txf_en) begin
                  flags_in.txf_en    = 1'b0;
                  flags_in.tx_active = 1'b0;
               end
            end
            KIND_RX_WORD: begin
               if (flags_ff.rx_on && !flags_ff.tx_active) begin
                  if (words_received_ff == '0) begin
                     status_in = data;
                     rx_next   = COUNT_W'(1);
                  end else if (words_received_ff < words_to_receive_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(words_received_ff - COUNT_W'(1));
                     rx_next = words_received_ff + COUNT_W'(1);
                  end
                  words_received_in = rx_next;
                  if (rx_next == words_to_receive_ff) begin
                     flags_in.rx_on = 1'b0;
                  end
                  parity_error_in = (odd_parity(data) != pbit);
                  bit_fault_in    = bfault;
               end
            end
            KIND_RX_SYNC: begin
               if (flags_ff.dir_req && flags_ff.rx_on && !flags_ff.sync_data &&
                   !flags_ff.tx_active) begin
                  flags_in.sync_data = 1'b1;
               end
            end
            KIND_WRITE_PAYLOAD: begin
               wr_en = 1'b1;
            end
            KIND_READ_PAYLOAD: begin
               s1_in.rd_from_mem = ({1'b0, idx} < eff);
            end
            default: begin
            end
         endcase
      end
      s1_in.mem_hit            = valid_ff[rd_addr];
      s1_in.channel_select     = flags_in.chan_b;
      s1_in.status_word        = status_in;
      s1_in.rx_count           = words_received_in;
      s1_in.parity_error       = parity_error_in;
      s1_in.bit_fault          = bit_fault_in;
      s1_in.receiver_on        = flags_in.rx_on;
      s1_in.sync_expects_data  = flags_in.sync_data;
      s1_in.transmitter_active = flags_in.tx_active;
   end

   bcts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WORDS)
   ) u_payload (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_tvalid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
      tx_word_out = s1_ff.tx_from_mem ? (s1_ff.mem_hit ? rd_data : '0) : s1_ff.tx_word;
      read_word_out = (s1_ff.rd_from_mem && s1_ff.mem_hit) ? rd_data : '0;
      rsp_tdata_in = {2'b00,
                      s1_ff.transmitter_active,
                      s1_ff.sync_expects_data,
                      s1_ff.receiver_on,
                      read_word_out,
                      s1_ff.bit_fault,
                      s1_ff.parity_error,
                      s1_ff.rx_count,
                      s1_ff.status_word,
                      s1_ff.channel_select,
                      tx_word_out,
                      s1_ff.tx_is_data,
                      s1_ff.tx_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_address_ff       <= '0;
         sub_address_ff      <= '0;
         word_count_ff       <= COUNT_W'(1);
         use_channel_b_ff    <= 1'b0;
         words_sent_ff       <= '0;
         words_to_send_ff    <= '0;
         words_received_ff   <= '0;
         words_to_receive_ff <= '0;
         flags_ff            <= '0;
         status_ff           <= '0;
         parity_error_ff     <= 1'b0;
         bit_fault_ff        <= 1'b0;
         valid_ff            <= '0;
         s1_valid_ff         <= 1'b0;
         rsp_tvalid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_RT_ADDRESS:    rt_address_ff    <= csr_wdata[4:0];
               CSR_SUB_ADDRESS:   sub_address_ff   <= csr_wdata[4:0];
               CSR_WORD_COUNT:    word_count_ff    <= csr_wdata[COUNT_W-1:0];
               CSR_USE_CHANNEL_B: use_channel_b_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         words_sent_ff       <= words_sent_in;
         words_to_send_ff    <= words_to_send_in;
         words_received_ff   <= words_received_in;
         words_to_receive_ff <= words_to_receive_in;
         flags_ff            <= flags_in;
         status_ff           <= status_in;
         parity_error_ff     <= parity_error_in;
         bit_fault_ff        <= bit_fault_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

### design/bcts_checker.sv
// Port-level checker for the bus controller transaction sequencer.
// Bound to the top level; depends on nothing else.
`default_nettype none

module bcts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   a_data_sync_needs_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> !rsp_tdata[1] && rsp_tdata[17:2] == 16'd0)
      else $error("transmit word without transmit valid");

   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[40:35] <= 6'd33)
      else $error("receive count out of range");

endmodule

bind bus_controller_transaction_sequencer bcts_checker u_bcts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/bus_controller_transaction_sequencer_tb.sv
// Self-checking testbench for the bus controller transaction sequencer.
// A scoreboard class predicts every response beat from the accepted events.
// Depends on bcts_pkg and the design top level.
`default_nettype none

module bus_controller_transaction_sequencer_tb
   import bcts_pkg::*;
();

   typedef struct packed {
      logic [1:0]  fill;
      logic        transmitter_active;
      logic        sync_expects_data;
      logic        receiver_on;
      logic [15:0] read_word;
      logic        bit_fault;
      logic        parity_error;
      logic [5:0]  rx_count;
      logic [15:0] status_word;
      logic        channel_select;
      logic [15:0] tx_word;
      logic        tx_word_is_data;
      logic        tx_valid;
   } rsp_fields_type;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_style_type;

   class scoreboard_type;
      bit [15:0] payload [MAX_WORDS];
      bit [5:0]  sent, to_send, received, to_receive;
      bit        dir_req, tx_active, txe_en, txf_en, rx_on, sync_data, chan_b;
      bit [15:0] status;
      bit        parity_err, bit_flt;
      bit [4:0]  rt, sub;
      bit [5:0]  wc;
      bit        use_b;
      int        failures;
      rsp_fields_type expected_beats [$];

      function new();
         wc = 6'd1;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function bit [5:0] span();
         if (wc == 6'd0)
            return 6'd1;
         else if (wc > 6'(MAX_WORDS))
            return 6'(MAX_WORDS);
         return wc;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] addr, bit [5:0] value);
         case (addr)
            CSR_RT_ADDRESS:    rt = value[4:0];
            CSR_SUB_ADDRESS:   sub = value[4:0];
            CSR_WORD_COUNT:    wc = value;
            CSR_USE_CHANNEL_B: use_b = value[0];
            default: ;
         endcase
      endfunction

      function void begin_transaction(bit request);
         sent = '0;
         received = '0;
         to_send = request ? 6'd1 : span() + 6'd1;
         to_receive = request ? span() + 6'd1 : 6'd1;
         txe_en = 1'b1;
         txf_en = 1'b1;
         rx_on = 1'b1;
         sync_data = 1'b0;
         dir_req = request;
         chan_b = use_b;
      endfunction

      function void note_event(kind_type kind, bit [4:0] idx, bit [15:0] data,
                               bit pbit, bit bfault);
         rsp_fields_type r;
         bit [5:0]  slot;
         bit [5:0]  cnt;
         r = '0;
         case (kind)
            KIND_START_SEND:    begin_transaction(1'b0);
            KIND_START_REQUEST: begin_transaction(1'b1);
            KIND_TX_EMPTY: begin
               if (txe_en) begin
                  if (sent == 6'd0) begin
                     cnt = span();
                     r.tx_valid = 1'b1;
                     r.tx_word = {rt, dir_req, sub, cnt[4:0]};
                     sent = 6'd1;
                     tx_active = 1'b1;
                  end else if (sent < to_send) begin
                     slot = sent - 6'd1;
                     r.tx_valid = 1'b1;
                     r.tx_word_is_data = 1'b1;
                     r.tx_word = (slot < 6'(MAX_WORDS)) ? payload[slot[4:0]] : 16'h0;
                     sent = sent + 6'd1;
                  end else begin
                     txe_en = 1'b0;
                  end
               end
            end
            KIND_TX_FINISHED: begin
               if (txf_en) begin
                  txf_en = 1'b0;
                  tx_active = 1'b0;
               end
            end
            KIND_RX_WORD: begin
               if (rx_on && !tx_active) begin
                  if (received == 6'd0) begin
                     status = data;
                     received = 6'd1;
                  end else if (received < to_receive) begin
                     slot = received - 6'd1;
                     if (slot < 6'(MAX_WORDS))
                        payload[slot[4:0]] = data;
                     received = received + 6'd1;
                  end
                  if (received == to_receive)
                     rx_on = 1'b0;
                  parity_err = ((~^data) != pbit);
                  bit_flt = bfault;
               end
            end
            KIND_RX_SYNC: begin
               if (dir_req && rx_on && !sync_data && !tx_active)
                  sync_data = 1'b1;
            end
            KIND_WRITE_PAYLOAD: payload[idx] = data;
            default: begin
               if (6'(idx) < span())
                  r.read_word = payload[idx];
            end
         endcase
         r.channel_select = chan_b;
         r.status_word = status;
         r.rx_count = received;
         r.parity_error = parity_err;
         r.bit_fault = bit_flt;
         r.receiver_on = rx_on;
         r.sync_expects_data = sync_data;
         r.transmitter_active = tx_active;
         expected_beats.push_back(r);
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 40)
               $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_beat(logic [RSP_DATA_W-1:0] raw);
         rsp_fields_type got, want;
         if (expected_beats.size() == 0) begin
            failures++;
            if (failures <= 40)
               $display("%0t unexpected beat: expected none actual %h", $time, raw);
            return;
         end
         got = raw;
         want = expected_beats.pop_front();
         compare("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
         compare("tx_word_is_data", 16'(want.tx_word_is_data), 16'(got.tx_word_is_data));
         compare("tx_word", want.tx_word, got.tx_word);
         compare("channel_select", 16'(want.channel_select), 16'(got.channel_select));
         compare("status_word", want.status_word, got.status_word);
         compare("rx_count", 16'(want.rx_count), 16'(got.rx_count));
         compare("parity_error", 16'(want.parity_error), 16'(got.parity_error));
         compare("bit_fault", 16'(want.bit_fault), 16'(got.bit_fault));
         compare("read_word", want.read_word, got.read_word);
         compare("receiver_on", 16'(want.receiver_on), 16'(got.receiver_on));
         compare("sync_expects_data", 16'(want.sync_expects_data),
                 16'(got.sync_expects_data));
         compare("transmitter_active", 16'(want.transmitter_active),
                 16'(got.transmitter_active));
         compare("fill", 16'(want.fill), 16'(got.fill));
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scoreboard_type  sb = new();
   int              events_offered = 0;
   int              burst_left = 0;
   int              rsp_hold = 0;
   int              style_left = 0;
   ready_style_type rsp_style = READY_ALWAYS;

   bus_controller_transaction_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         case (rsp_style)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            default:      rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
         if (style_left == 0) begin
            rsp_style = ready_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(10, 80);
         end else begin
            style_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tdata);
   end

   task automatic offer_event(kind_type kind, bit [4:0] idx, bit [15:0] data,
                              bit pbit, bit bfault);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, bfault, pbit, data, idx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_event(kind, idx, data, pbit, bfault);
      events_offered++;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic offer_random(kind_type kind);
      offer_event(kind, 5'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // mostly clean words, now and then a parity slip or a bit fault
   task automatic offer_rx(bit [15:0] data);
      offer_event(KIND_RX_WORD, 5'($urandom), data,
                  (~^data) ^ ($urandom_range(0, 7) == 0), $urandom_range(0, 7) == 0);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] addr, bit [5:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(addr, value);
   endtask

   task automatic configure(bit [5:0] rt, bit [5:0] sub, bit [5:0] wc, bit [5:0] chan);
      write_csr(CSR_RT_ADDRESS, rt);
      write_csr(CSR_SUB_ADDRESS, sub);
      write_csr(CSR_WORD_COUNT, wc);
      write_csr(CSR_USE_CHANNEL_B, chan);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_transaction();
      bit       request;
      bit [5:0] count;
      int       cut;
      request = 1'($urandom);
      count = sb.span();
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
      if (!request)
         repeat ($urandom_range(0, 3))
            offer_event(KIND_WRITE_PAYLOAD, 5'($urandom_range(0, count - 1)),
                        16'($urandom), 1'($urandom), 1'($urandom));
      offer_random(request ? KIND_START_REQUEST : KIND_START_SEND);
      for (int i = 0; i <= (request ? 0 : int'(count)); i++) begin
         offer_random(KIND_TX_EMPTY);
         if ($urandom_range(0, 7) == 0)
            offer_random(KIND_RX_WORD);
         if (i == cut)
            return;
      end
      if ($urandom_range(0, 5) == 0)
         offer_random(KIND_RX_SYNC);
      offer_random(KIND_TX_EMPTY);
      if ($urandom_range(0, 15) != 0)
         offer_random(KIND_TX_FINISHED);
      if (request && $urandom_range(0, 9) < 7)
         offer_random(KIND_RX_SYNC);
      for (int i = 0; i < (request ? int'(count) + 1 : 1) + $urandom_range(0, 1); i++)
         offer_rx(16'($urandom));
      if (request && $urandom_range(0, 3) == 0)
         offer_random(KIND_RX_SYNC);
      repeat ($urandom_range(0, 3))
         offer_random(KIND_READ_PAYLOAD);
      if ($urandom_range(0, 3) == 0)
         offer_random(kind_type'($urandom_range(0, 7)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(6'd31, 6'd21, 6'd2, 6'd1);
      offer_event(KIND_WRITE_PAYLOAD, 5'd0, 16'hffff, 1'b1, 1'b1);
      offer_event(KIND_WRITE_PAYLOAD, 5'd31, 16'h0000, 1'b0, 1'b0);
      offer_event(KIND_WRITE_PAYLOAD, 5'd1, 16'ha5a5, 1'b0, 1'b0);
      offer_event(KIND_READ_PAYLOAD, 5'd31, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_READ_PAYLOAD, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_EMPTY, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'h1234, 1'b0, 1'b1);
      offer_event(KIND_RX_SYNC, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_FINISHED, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_START_SEND, 5'd0, 16'h0, 1'b0, 1'b0);
      repeat (3) offer_event(KIND_TX_EMPTY, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'hbeef, 1'b1, 1'b1);
      offer_event(KIND_RX_SYNC, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_EMPTY, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_FINISHED, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'h0001, 1'b1, 1'b1);
      offer_event(KIND_START_REQUEST, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_EMPTY, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_SYNC, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_EMPTY, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_TX_FINISHED, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_SYNC, 5'd0, 16'h0, 1'b0, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'h8000, 1'b1, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'h7fff, 1'b1, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'hffff, 1'b0, 1'b0);
      offer_event(KIND_RX_WORD, 5'd0, 16'h5555, 1'b1, 1'b0);
      offer_event(KIND_START_SEND, 5'd0, 16'h0, 1'b0, 1'b0);

      for (int phase = 0; events_offered < 720; phase++) begin
         drain();
         case (phase)
            0: configure(6'd0, 6'd0, 6'd0, 6'd0);
            1: configure(6'd63, 6'd63, 6'd63, 6'd63);
            2: configure(6'($urandom), 6'($urandom), 6'd32, 6'($urandom));
            3: configure(6'($urandom), 6'($urandom), 6'd1, 6'($urandom));
            default: configure(6'($urandom), 6'($urandom),
                               ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                           : 6'($urandom_range(0, 5)),
                               6'($urandom));
         endcase
         if (phase == 2) begin
            rsp_hold = 120;
            burst_left = 300;
         end
         repeat (5) run_transaction();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
design/bcts_pkg.sv
design/bcts_ram.sv
design/bus_controller_transaction_sequencer.sv
design/bcts_checker.sv
tb/bus_controller_transaction_sequencer_tb.sv
